// File: rtl/histogram_row_mean_stddev_top_macros.svh
// Assertion macros for the histogram row statistics RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef HISTOGRAM_ROW_MEAN_STDDEV_TOP_MACROS_SVH
`define HISTOGRAM_ROW_MEAN_STDDEV_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRMS_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hrms assertion failed");

// Next-cycle implication, disabled during reset.
`define HRMS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hrms assertion failed");

`endif

// File: rtl/hrms_pkg.sv
// Package for the histogram row statistics block: widths, step counts,
// state and datapath operation codes, and the controller-to-datapath command.
package hrms_pkg;

  localparam int BIN_W      = 24;
  localparam int BIN_BITS   = 24;
  localparam int SUM_W      = 36;
  localparam int SQ_W       = 60;
  localparam int CNT_W      = 13;
  localparam int ROW_W      = 9;
  localparam int MAX_ROWS   = 512;
  localparam int MEAN_W     = 40;
  localparam int SCALED_W   = 43;
  localparam int MUL_W      = SQ_W + CNT_W;
  localparam int MPLIER_W   = SUM_W;
  localparam int DIV_W      = MUL_W + 32;
  localparam int DEN_W      = 2 * CNT_W;
  localparam int ROOT_W     = (DIV_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int MUL_STEPS  = MPLIER_W;
  localparam int DIV_STEPS  = DIV_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [BIN_W-1:0] BIN_MASK = BIN_W'((64'd1 << BIN_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_DIV_VAR, S_SQRT, S_DIV_MEAN, S_OUT
  } hrms_state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_MUL_A_LOAD, DP_MUL_B_LOAD, DP_MUL_STEP, DP_DIV_VAR_LOAD,
    DP_DIV_MEAN_LOAD, DP_DIV_STEP, DP_SQRT_LOAD, DP_SQRT_STEP, DP_OUT_LOAD
  } hrms_op_t;

  typedef struct packed {
    logic     acc_en;
    logic     snap;
    hrms_op_t op;
  } hrms_cmd_t;

endpackage

// File: rtl/hrms_ctrl.sv
// Controller of the histogram row statistics block: handshakes and the
// sequence of multiply, divide and square-root steps. Uses hrms_pkg and macros.
`include "histogram_row_mean_stddev_top_macros.svh"

module hrms_ctrl import hrms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      row_end,
  input  logic      histogram_end,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output hrms_cmd_t cmd
);

  hrms_state_t        state, state_next;
  logic [STEP_W-1:0]  cnt, cnt_next;
  logic [STEP_W-1:0]  last;
  logic               row_done;
  logic               out_load;

  assign row_done = row_end || histogram_end;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    unique case (state)
      S_MUL_A, S_MUL_B:       last = STEP_W'(MUL_STEPS);
      S_DIV_VAR, S_DIV_MEAN:  last = STEP_W'(DIV_STEPS);
      S_SQRT:                 last = STEP_W'(SQRT_STEPS);
      default:                last = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (cmd.snap) state_next = S_MUL_A;
      S_MUL_A:    if (cnt == last) state_next = S_MUL_B;
      S_MUL_B:    if (cnt == last) state_next = S_DIV_VAR;
      S_DIV_VAR:  if (cnt == last) state_next = S_SQRT;
      S_SQRT:     if (cnt == last) state_next = S_DIV_MEAN;
      S_DIV_MEAN: if (cnt == last) state_next = S_OUT;
      S_OUT:      if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
    if (state_next != state || state == S_IDLE || state == S_OUT) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt + STEP_W'(1);
    end
  end

  always_comb begin
    in_ready   = (state == S_IDLE) || !row_done;
    cmd.acc_en = in_valid && in_ready;
    cmd.snap   = in_valid && in_ready && row_done;
    cmd.op     = DP_NOP;
    unique case (state)
      S_MUL_A:    cmd.op = (cnt == '0) ? DP_MUL_A_LOAD : DP_MUL_STEP;
      S_MUL_B:    cmd.op = (cnt == '0) ? DP_MUL_B_LOAD : DP_MUL_STEP;
      S_DIV_VAR:  cmd.op = (cnt == '0) ? DP_DIV_VAR_LOAD : DP_DIV_STEP;
      S_SQRT:     cmd.op = (cnt == '0) ? DP_SQRT_LOAD : DP_SQRT_STEP;
      S_DIV_MEAN: cmd.op = (cnt == '0) ? DP_DIV_MEAN_LOAD : DP_DIV_STEP;
      S_OUT:      cmd.op = out_load ? DP_OUT_LOAD : DP_NOP;
      default:    cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HRMS_ASSERT_IMPLY(a_snap_idle, clk, rst, cmd.snap, state == S_IDLE)
  `HRMS_ASSERT_IMPLY(a_stall_busy, clk, rst, !in_ready, state != S_IDLE)
  `HRMS_ASSERT_NEXT(a_load_shows, clk, rst, out_load, out_valid)

endmodule

// File: rtl/hrms_datapath.sv
// Datapath of the histogram row statistics block: accumulators, a serial
// multiplier, a restoring divider, a digit square root and the result register.
module hrms_datapath import hrms_pkg::*; #(
  parameter int ROW_LIMIT = MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  hrms_cmd_t           cmd,
  input  logic [BIN_W-1:0]    bin_value,
  input  logic                histogram_end,
  output logic [ROW_W-1:0]    row_index,
  output logic [CNT_W-1:0]    positive_count,
  output logic [MEAN_W-1:0]   row_mean,
  output logic [SCALED_W-1:0] mean_q19,
  output logic [MEAN_W-1:0]   row_stddev,
  output logic                mean_valid,
  output logic                stddev_valid
);

  logic [SUM_W-1:0]    sum_acc, sum_s, sum_new;
  logic [SQ_W-1:0]     sq_acc, sq_s, sq_new;
  logic [CNT_W-1:0]    tally, n_s, tally_new;
  logic [ROW_W-1:0]    row_cnt, row_s, row_next;
  logic [BIN_W-1:0]    v;
  logic [2*BIN_W-1:0]  sq_bin;
  logic [SUM_W:0]      sum_wide;
  logic [SQ_W:0]       sq_wide;
  logic [ROW_W:0]      row_inc;

  logic [MUL_W-1:0]    mcand, prod, a_prod, diff;
  logic [MPLIER_W-1:0] mplier;
  logic                neg;

  logic [DIV_W-1:0]    dvd;
  logic [DEN_W-1:0]    rem, den;
  logic [DEN_W:0]      rem_sh, rem_diff;

  logic [RAD_W-1:0]    rad;
  logic [SREM_W-1:0]   srem, srem_sh, trial;
  logic [ROOT_W-1:0]   root;
  logic [MEAN_W-1:0]   sd_hold;
  logic                q_big;

  assign v        = bin_value & BIN_MASK;
  assign sq_bin   = (2*BIN_W)'(v) * (2*BIN_W)'(v);
  assign sum_wide = {1'b0, sum_acc} + (SUM_W+1)'(v);
  assign sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign sq_wide  = {1'b0, sq_acc} + (SQ_W+1)'(sq_bin);
  assign sq_new   = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
  assign tally_new = (v != '0 && tally != '1) ? tally + CNT_W'(1) : tally;
  assign row_inc  = {1'b0, row_cnt} + (ROW_W+1)'(1);
  assign row_next = histogram_end ? '0 :
                    (row_inc >= (ROW_W+1)'(ROW_LIMIT)) ? '0 : row_inc[ROW_W-1:0];

  assign diff     = a_prod - prod;
  assign rem_sh   = {rem, dvd[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign srem_sh  = {srem[SREM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign q_big    = |dvd[2*SUM_W-17:SCALED_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc <= '0;
      sq_acc  <= '0;
      tally   <= '0;
      row_cnt <= '0;
    end else if (cmd.acc_en) begin
      if (cmd.snap) begin
        sum_acc <= '0;
        sq_acc  <= '0;
        tally   <= '0;
        row_cnt <= row_next;
      end else begin
        sum_acc <= sum_new;
        sq_acc  <= sq_new;
        tally   <= tally_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      sum_s <= sum_new;
      sq_s  <= sq_new;
      n_s   <= tally_new;
      row_s <= row_cnt;
    end
    unique case (cmd.op)
      DP_MUL_A_LOAD: begin
        mcand  <= MUL_W'(sq_s);
        mplier <= MPLIER_W'(n_s);
        prod   <= '0;
      end
      DP_MUL_B_LOAD: begin
        a_prod <= prod;
        mcand  <= MUL_W'(sum_s);
        mplier <= sum_s;
        prod   <= '0;
      end
      DP_MUL_STEP: begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= {mcand[MUL_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[MPLIER_W-1:1]};
      end
      DP_DIV_VAR_LOAD: begin
        neg <= prod > a_prod;
        dvd <= {diff, 32'b0};
        den <= DEN_W'(n_s) * DEN_W'(n_s - CNT_W'(1));
        rem <= '0;
      end
      DP_DIV_MEAN_LOAD: begin
        sd_hold <= (neg || n_s < CNT_W'(2)) ? '0 :
                   (|root[ROOT_W-1:MEAN_W]) ? '1 : root[MEAN_W-1:0];
        dvd <= DIV_W'({sum_s, 19'b0});
        den <= DEN_W'(n_s);
        rem <= '0;
      end
      DP_DIV_STEP: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_diff[DEN_W-1:0];
          dvd <= {dvd[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_W-1:0];
          dvd <= {dvd[DIV_W-2:0], 1'b0};
        end
      end
      DP_SQRT_LOAD: begin
        rad  <= RAD_W'(dvd);
        srem <= '0;
        root <= '0;
      end
      DP_SQRT_STEP: begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem <= srem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          srem <= srem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      DP_OUT_LOAD: begin
        row_index      <= row_s;
        positive_count <= n_s;
        row_mean       <= (n_s == '0) ? '0 : q_big ? '1 : dvd[SCALED_W-1:3];
        mean_q19       <= (n_s == '0) ? '0 : q_big ? '1 : dvd[SCALED_W-1:0];
        row_stddev     <= sd_hold;
        mean_valid     <= n_s != '0;
        stddev_valid   <= n_s > CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/histogram_row_mean_stddev_top.sv
// Top level of the histogram row statistics block.
// Depends on hrms_pkg, hrms_ctrl and hrms_datapath.
//
//  Channel  Handshake            Carries
//  -------  -------------------  ------------------------------------------------
//  in       in_valid / in_ready  bin_value, row_end, histogram_end
//  out      out_valid/out_ready  row_index, positive_count, row_mean, mean_q19,
//                                row_stddev, mean_valid, stddev_valid
//
// Bins that do not end a row are taken one per cycle. A bin that ends a row is
// taken only while the arithmetic unit is free; it then runs two 36-step serial
// multiplies, two 105-step restoring divides on one shared serial divider and a
// 53-step square root.
// Bins of the next row keep streaming in while that work goes on.
// Reset is synchronous and clears accumulators, row index, sequencer and out_valid.
// A stalled output holds its result; the next result waits in the sequencer.
module histogram_row_mean_stddev_top import hrms_pkg::*; #(
  parameter int ROW_LIMIT = MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BIN_W-1:0]    bin_value,
  input  logic                row_end,
  input  logic                histogram_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROW_W-1:0]    row_index,
  output logic [CNT_W-1:0]    positive_count,
  output logic [MEAN_W-1:0]   row_mean,
  output logic [SCALED_W-1:0] mean_q19,
  output logic [MEAN_W-1:0]   row_stddev,
  output logic                mean_valid,
  output logic                stddev_valid
);

  hrms_cmd_t cmd;

  // The controller owns both handshakes and issues one datapath command per cycle.
  hrms_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .row_end       (row_end),
    .histogram_end (histogram_end),
    .in_ready      (in_ready),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .cmd           (cmd)
  );

  // The datapath accumulates each row and computes its mean and deviation.
  // The row index wraps to zero instead of reaching ROW_LIMIT, and restarts at zero after histogram_end.
  hrms_datapath #(
    .ROW_LIMIT (ROW_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .bin_value      (bin_value),
    .histogram_end  (histogram_end),
    .row_index      (row_index),
    .positive_count (positive_count),
    .row_mean       (row_mean),
    .mean_q19       (mean_q19),
    .row_stddev     (row_stddev),
    .mean_valid     (mean_valid),
    .stddev_valid   (stddev_valid)
  );

endmodule
